@@ design/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, control structs, state encoding and the reciprocal table
// used by the divide-by-radix unit.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int DIGIT_DEPTH = 16;
  localparam int VALUE_BITS  = 31;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 4;
  localparam int REM_W   = 5;
  localparam int CNT_W   = $clog2(DIGIT_DEPTH + 1);
  localparam int PTR_W   = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;
  localparam int RECIP_W = VALUE_BITS + 1;
  localparam int PROD_W  = VALUE_BITS + RECIP_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

  localparam logic [RECIP_W:0] ONE_K = {1'b1, {RECIP_W{1'b0}}};
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(ONE_K / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(ONE_K / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(ONE_K / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(ONE_K / 5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(ONE_K / 6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'(ONE_K / 7);
  localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(ONE_K / 8);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(ONE_K / 9);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [DIGIT_W-1:0]    digit;
  } div_res_t;

  typedef struct packed {
    logic               push;
    logic [PTR_W-1:0]   push_addr;
    logic [DIGIT_W-1:0] push_data;
    logic               pop;
    logic [PTR_W-1:0]   pop_addr;
  } stk_ctrl_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      4'd3:    m = RECIP_3;
      4'd4:    m = RECIP_4;
      4'd5:    m = RECIP_5;
      4'd6:    m = RECIP_6;
      4'd7:    m = RECIP_7;
      4'd8:    m = RECIP_8;
      4'd9:    m = RECIP_9;
      default: m = RECIP_2;
    endcase
    return m;
  endfunction

endpackage

@@ design/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// Divide-by-radix unit
// Registered divider: a reciprocal multiply estimates the quotient, then one
// multiply-back, subtract and compare corrects it and yields the remainder.
// ----------------------------------------------------------------------------
module rdc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [rdc_pkg::VALUE_BITS-1:0] dividend,
  input  logic [rdc_pkg::RADIX_W-1:0]    radix,
  output rdc_pkg::div_res_t             res
);
  import rdc_pkg::*;

  logic                  stage;
  logic                  done_q;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] dvd;
  logic [RADIX_W-1:0]    radix_q;
  logic [VALUE_BITS-1:0] quotient_q;
  logic [DIGIT_W-1:0]    digit_q;

  logic [VALUE_BITS-1:0] q_est;
  logic [VALUE_BITS-1:0] q_times_r;
  logic [VALUE_BITS-1:0] diff;
  logic [REM_W-1:0]      rem_raw;
  logic [REM_W-1:0]      rem_fix;
  logic [VALUE_BITS-1:0] q_fix;
  logic                  fix;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stage  <= go;
      done_q <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod    <= PROD_W'(dividend) * PROD_W'(recip(radix));
      dvd     <= dividend;
      radix_q <= radix;
    end
  end

  always_ff @(posedge clk) begin
    if (stage) begin
      quotient_q <= q_fix;
      digit_q    <= rem_fix[DIGIT_W-1:0];
    end
  end

  always_comb begin
    q_est     = prod[PROD_W-1:RECIP_W];
    q_times_r = VALUE_BITS'(q_est * VALUE_BITS'(radix_q));
    diff      = dvd - q_times_r;
    rem_raw   = diff[REM_W-1:0];
    fix       = rem_raw >= REM_W'(radix_q);
    rem_fix   = fix ? (rem_raw - REM_W'(radix_q)) : rem_raw;
    q_fix     = fix ? (q_est + VALUE_BITS'(1)) : q_est;
    res.done     = done_q;
    res.quotient = quotient_q;
    res.digit    = digit_q;
  end

endmodule

@@ design/rdc_digit_stack.sv @@
// ----------------------------------------------------------------------------
// Digit stack
// Small digit memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rdc_digit_stack (
  input  logic                        clk,
  input  rdc_pkg::stk_ctrl_t          ctrl,
  output logic [rdc_pkg::DIGIT_W-1:0] rd_data
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] mem [DIGIT_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[ctrl.push_addr] <= ctrl.push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rd_data <= mem[ctrl.pop_addr];
    end
  end

endmodule

@@ design/radix_digit_converter_unit.sv @@
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts one value per transfer to radix 2 to 9 digits by repeated division
// and emits them most significant first, one strobed digit per cycle.
// ----------------------------------------------------------------------------
// With n kept digits (1 to 16), an item holds busy while the shared
// divide-by-radix unit yields each digit in turn, then for one stack read per
// digit. Digits are strobed from the registered stack read port, and they
// follow in consecutive cycles; the receiver cannot stall them.
// Synchronous reset returns the sequencer to idle and sets the radix to two.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rdc_pkg::VALUE_BITS-1:0] value,
  input  logic                          radix_we,
  input  logic [rdc_pkg::RADIX_W-1:0]    radix_data,
  output logic                          strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]    digit,
  output logic                          last_digit,
  output logic                          overflow
);
  import rdc_pkg::*;

  state_t state, state_next;

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_eff;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [CNT_W-1:0]   cnt_plus;
  logic [CNT_W-1:0]   cnt_minus;
  logic               dropped, dropped_next;
  logic               last_q;
  logic               overflow_q;

  logic                  div_go;
  logic [VALUE_BITS-1:0] dividend;
  div_res_t              div_res;
  stk_ctrl_t             stk;

  assign radix_eff = (radix < RADIX_MIN) ? RADIX_MIN :
                     (radix > RADIX_MAX) ? RADIX_MAX : radix;
  assign cnt_plus  = cnt + CNT_W'(1);
  assign cnt_minus = cnt - CNT_W'(1);

  rdc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (dividend),
    .radix    (radix_eff),
    .res      (div_res)
  );

  rdc_digit_stack u_stack (
    .clk     (clk),
    .ctrl    (stk),
    .rd_data (digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      dropped <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      dropped <= dropped_next;
      strobe  <= stk.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (stk.pop) begin
      last_q     <= (cnt == CNT_W'(1));
      overflow_q <= dropped;
    end
  end

  assign last_digit = last_q;
  assign overflow   = overflow_q;
  assign busy       = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dropped_next = dropped;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next   = ST_DIVIDE;
          cnt_next     = '0;
          dropped_next = 1'b0;
        end
      end
      ST_DIVIDE: begin
        if (div_res.done) begin
          cnt_next = cnt_plus;
          if (div_res.quotient == '0) begin
            state_next = ST_EMIT;
          end else if (cnt_plus == CNT_W'(DIGIT_DEPTH)) begin
            state_next   = ST_EMIT;
            dropped_next = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cnt_next = cnt_minus;
        if (cnt == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    div_go        = 1'b0;
    dividend      = div_res.quotient;
    stk.push      = 1'b0;
    stk.push_addr = cnt[PTR_W-1:0];
    stk.push_data = div_res.digit;
    stk.pop       = 1'b0;
    stk.pop_addr  = cnt_minus[PTR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        dividend = value;
        div_go   = start;
      end
      ST_DIVIDE: begin
        stk.push = div_res.done;
        div_go   = div_res.done && (div_res.quotient != '0) &&
                   (cnt_plus != CNT_W'(DIGIT_DEPTH));
      end
      ST_EMIT: begin
        stk.pop = 1'b1;
      end
      default: begin
        div_go = 1'b0;
      end
    endcase
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && last_digit |=> !strobe)
    else $error("digit strobed right after the final digit of a run");

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_digit |=> strobe)
    else $error("gap inside a digit run");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DIGIT_DEPTH))
    else $error("stack count beyond depth");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIVIDE)
    else $error("divider result outside the divide phase");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

endmodule
